/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   `ASSERT_CLK(label, clk, rst, (pre) |=> (post), msg)

`endif

/* rtl/core/u8sv_pkg.sv */
// ----------------------------------------------------------------------------
// u8sv_pkg
// Types and code point limits of the UTF-8 stream validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8sv_pkg;

   localparam int ACC_WIDTH = 21;

   typedef logic [ACC_WIDTH-1:0] code_type;
   typedef logic [1:0]           count_type;

   // Smallest code point that each sequence length may legally encode.
   localparam code_type MIN_TWO_BYTE   = 21'h00080;
   localparam code_type MIN_THREE_BYTE = 21'h00800;
   localparam code_type MIN_FOUR_BYTE  = 21'h10000;

   localparam code_type MAX_CODE       = 21'h10FFFF;
   localparam code_type SURROGATE_LO   = 21'h0D800;
   localparam code_type SURROGATE_HI   = 21'h0DFFF;

   // Continuation counts (bytes still expected after the lead).
   localparam count_type CONT_NONE  = 2'd0;
   localparam count_type CONT_ONE   = 2'd1;
   localparam count_type CONT_TWO   = 2'd2;
   localparam count_type CONT_THREE = 2'd3;

endpackage

`default_nettype wire

/* rtl/core/utf8_stream_validator.sv */
// Result goes to the output register, or the skid register if held; decode is one short
// step from the state registers. Throughput: one byte per cycle while req_stall is low.
// A two-entry result buffer (output register plus skid register) keeps bytes flowing
// while a result waits; req_stall rises only when both entries are full.
// Reset (synchronous, active high) clears the decode state and empties the result buffer.
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Checks a byte stream for well-formed UTF-8 and reports once per string.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_validator
   import u8sv_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // input channel: one byte of the string per item
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   // result channel: one item per string
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_string_valid
);

   // Decode state of the string in flight.
   count_type pending_ff, pending_in;
   count_type seqlen_ff,  seqlen_in;
   code_type  acc_ff,     acc_in;
   logic      error_ff,   error_in;

   // Next values as if the current byte were taken, before the end-of-string clear.
   count_type pending_nx;
   count_type seqlen_nx;
   code_type  acc_nx;
   logic      error_nx;
   logic      verdict;

   // Result buffer: output register and skid register.
   logic main_valid_ff, main_valid_in;
   logic main_data_ff,  main_data_in;
   logic skid_valid_ff, skid_valid_in;
   logic skid_data_ff,  skid_data_in;

   logic req_take;
   logic rsp_take;
   logic new_result;

   assign req_take   = req_valid && !req_stall;
   assign rsp_take   = main_valid_ff && !rsp_stall;
   assign new_result = req_take && req_last_byte;

   // Hold the input only when both result entries are occupied.
   assign req_stall = skid_valid_ff;

   // ---------------------------------------------------------------------
   // Byte decode
   // ---------------------------------------------------------------------
   always_comb begin
      pending_nx = pending_ff;
      seqlen_nx  = seqlen_ff;
      acc_nx     = acc_ff;
      error_nx   = error_ff;

      if (pending_ff == CONT_NONE) begin
         // Lead byte: open a new character.
         if (!req_data_byte[7]) begin
            if (req_data_byte == 8'h00) begin
               error_nx = 1'b1;
            end
         end else if (req_data_byte[7:5] == 3'b110) begin
            pending_nx = CONT_ONE;
            seqlen_nx  = CONT_ONE;
            acc_nx     = code_type'(req_data_byte[4:0]);
         end else if (req_data_byte[7:4] == 4'b1110) begin
            pending_nx = CONT_TWO;
            seqlen_nx  = CONT_TWO;
            acc_nx     = code_type'(req_data_byte[3:0]);
         end else if (req_data_byte[7:3] == 5'b11110) begin
            pending_nx = CONT_THREE;
            seqlen_nx  = CONT_THREE;
            acc_nx     = code_type'(req_data_byte[2:0]);
         end else begin
            // stray continuation byte or a lead of five bytes or more
            error_nx = 1'b1;
         end
      end else begin
         if (req_data_byte[7:6] != 2'b10) begin
            // Drop the character; the byte is not decoded again as a lead.
            error_nx   = 1'b1;
            pending_nx = CONT_NONE;
         end else begin
            acc_nx     = {acc_ff[ACC_WIDTH-7:0], req_data_byte[5:0]};
            pending_nx = pending_ff - 2'd1;
            if (pending_nx == CONT_NONE) begin
               // Character complete: reject overlong, out of range, surrogate.
               if ((seqlen_ff == CONT_ONE   && acc_nx < MIN_TWO_BYTE)   ||
                   (seqlen_ff == CONT_TWO   && acc_nx < MIN_THREE_BYTE) ||
                   (seqlen_ff == CONT_THREE && acc_nx < MIN_FOUR_BYTE)  ||
                   (acc_nx > MAX_CODE) ||
                   (acc_nx >= SURROGATE_LO && acc_nx <= SURROGATE_HI)) begin
                  error_nx = 1'b1;
               end
            end
         end
      end

      // A string cut short inside a character fails too.
      verdict = !error_nx && (pending_nx == CONT_NONE);
   end

   // Advance the decode state on each taken byte; clear it after the final byte.
   always_comb begin
      pending_in = pending_ff;
      seqlen_in  = seqlen_ff;
      acc_in     = acc_ff;
      error_in   = error_ff;
      if (req_take) begin
         if (req_last_byte) begin
            pending_in = CONT_NONE;
            seqlen_in  = CONT_NONE;
            acc_in     = '0;
            error_in   = 1'b0;
         end else begin
            pending_in = pending_nx;
            seqlen_in  = seqlen_nx;
            acc_in     = acc_nx;
            error_in   = error_nx;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result buffer
   // ---------------------------------------------------------------------
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;

      if (!main_valid_ff || rsp_take) begin
         // Output register frees up: refill from the skid first, else from decode.
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (new_result) begin
            main_valid_in = 1'b1;
            main_data_in  = verdict;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (new_result) begin
         // Output held downstream: park the new result in the skid.
         skid_valid_in = 1'b1;
         skid_data_in  = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= CONT_NONE;
         seqlen_ff     <= CONT_NONE;
         acc_ff        <= '0;
         error_ff      <= 1'b0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         pending_ff    <= pending_in;
         seqlen_ff     <= seqlen_in;
         acc_ff        <= acc_in;
         error_ff      <= error_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = main_valid_ff;
   assign rsp_string_valid = main_data_ff;

endmodule

`default_nettype wire

/* rtl/core/u8sv_checker.sv */
// ----------------------------------------------------------------------------
// u8sv_checker
// Port-level checks of the UTF-8 stream validator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module u8sv_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [7:0] req_data_byte,
   input wire logic       req_last_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_string_valid
);

   // A held result stays in place.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_string_valid), "held result changed")

   // With the output empty, a final byte shows its result on the next cycle.
   `ASSERT_NEXT(a_rsp_next, clock, reset, req_valid && !req_stall && req_last_byte && !rsp_valid, rsp_valid, "result did not follow final byte")

   // A zero final byte always fails the string.
   `ASSERT_NEXT(a_zero_fails, clock, reset, req_valid && !req_stall && req_last_byte && !rsp_valid && req_data_byte == 8'h00, rsp_valid && !rsp_string_valid, "zero byte passed")

   // The input stalls only behind a result that was held in the previous cycle.
   `ASSERT_CLK(a_stall_cause, clock, reset, req_stall |-> $past(rsp_valid && rsp_stall), "input stalled without a held result")

endmodule

bind utf8_stream_validator u8sv_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_data_byte    (req_data_byte),
   .req_last_byte    (req_last_byte),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_string_valid (rsp_string_valid)
);

`default_nettype wire
